// File: rtl/core/loop_halfedge_refine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the halfedge refinement block
// Implication and next-cycle implication checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef LOOP_HALFEDGE_REFINE_ASSERT_SVH
`define LOOP_HALFEDGE_REFINE_ASSERT_SVH

`ifndef SYNTH
`define LHR_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
`define LHR_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define LHR_ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define LHR_ASSERT_NXT(lbl, ck, rs, ante, cons, msg)
`endif

`endif

// File: rtl/core/lhr_pkg.sv
// ----------------------------------------------------------------------------
// Halfedge refinement package
// Shared types, codes and small arithmetic helpers.
// ----------------------------------------------------------------------------
package lhr_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 13;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_REFINE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_HALFEDGE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_COUNT     = 2'd2;

  localparam logic [1:0] SLOT_CORNER0 = 2'd0;
  localparam logic [1:0] SLOT_CORNER1 = 2'd1;
  localparam logic [1:0] SLOT_CORNER2 = 2'd2;
  localparam logic [1:0] SLOT_INNER   = 2'd3;

  // Quotient by three of a 12-bit value: (x * 2731) >> 13 is exact below 4096.
  localparam int DIV3_MUL   = 2731;
  localparam int DIV3_SHIFT = 13;
  localparam int DIV3_PW    = 24;

  typedef struct packed {
    logic [12:0] twin;
    logic [11:0] vertex;
    logic [11:0] edge_id;
  } entry_t;

  typedef struct packed {
    logic [11:0] h;
    logic [1:0]  hr;
    logic [10:0] hq;
    logic [12:0] p;
    logic        h_ok;
    logic        p_ok;
  } ctx_t;

  typedef struct packed {
    logic [13:0] idx;
    logic [14:0] twin;
    logic [13:0] nxt;
    logic [13:0] prv;
    logic [12:0] vertex;
    logic [13:0] edge_id;
    logic [12:0] face;
    logic        last;
  } child_t;

  // Residue modulo three by summing base-4 digits, since 4 is 1 modulo 3.
  function automatic logic [1:0] mod3_12(input logic [11:0] x);
    logic [4:0] s;
    logic [2:0] s2;
    logic [2:0] s3;
    s = '0;
    for (int i = 0; i < 6; i++) begin
      s = s + 5'(x[2*i +: 2]);
    end
    s2 = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
  endfunction

endpackage

// File: rtl/core/lhr_table.sv
// ----------------------------------------------------------------------------
// Halfedge table memory
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module lhr_table #(
  parameter int DEPTH = 4096
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  lhr_pkg::entry_t       wdata,
  input  logic                  re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output lhr_pkg::entry_t       rdata_a,
  output lhr_pkg::entry_t       rdata_b
);

  lhr_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: rtl/core/lhr_child.sv
// ----------------------------------------------------------------------------
// Child halfedge generator
// Builds one of the four child halfedges of a refined halfedge per slot.
// ----------------------------------------------------------------------------
module lhr_child (
  input  lhr_pkg::ctx_t   ctx,
  input  lhr_pkg::entry_t ent_h,
  input  lhr_pkg::entry_t ent_p,
  input  logic [12:0]     halfedge_count,
  input  logic [12:0]     vertex_count,
  input  logic [12:0]     edge_count,
  input  logic [1:0]      slot,
  output lhr_pkg::child_t child
);

  lhr_pkg::entry_t    eh;
  lhr_pkg::entry_t    ep;
  logic signed [14:0] t15;
  logic signed [14:0] tp15;
  logic signed [14:0] h15;
  logic signed [14:0] p15;
  logic signed [14:0] t3;
  logic signed [14:0] tp3;
  logic signed [14:0] t0;
  logic [1:0]         tr;
  logic               c0;
  logic               c2;
  logic [13:0]        b;
  logic [14:0]        h3;
  logic [14:0]        tw1;
  logic [12:0]        nh;
  logic [13:0]        b4n;
  logic [13:0]        b4p;
  logic [12:0]        vh;
  logic [12:0]        vp;
  logic [13:0]        e2h;
  logic [13:0]        edge0;
  logic [13:0]        edge2;
  logic [12:0]        face_h;
  logic [12:0]        face3;

  always_comb begin
    eh = ctx.h_ok ? ent_h : '0;
    ep = ctx.p_ok ? ent_p : '0;

    t15  = {{2{eh.twin[12]}}, eh.twin};
    tp15 = {{2{ep.twin[12]}}, ep.twin};
    h15  = $signed({3'b000, ctx.h});
    p15  = $signed({2'b00, ctx.p});
    t3   = (t15 <<< 1) + t15;
    tp3  = (tp15 <<< 1) + tp15;
    tr   = lhr_pkg::mod3_12(eh.twin[11:0]);
    t0   = t15[14] ? t3 + 15'sd2 : ((tr == 2'd2) ? t3 - 15'sd4 : t3 + 15'sd5);
    c0   = (h15 > t15) ? 1'b0 : 1'b1;
    c2   = (p15 > tp15) ? 1'b1 : 1'b0;

    b    = ({2'b00, ctx.h} << 1) + {2'b00, ctx.h};
    h3   = ({2'b00, halfedge_count} << 1) + {2'b00, halfedge_count};
    tw1  = h3 + {3'b000, ctx.h};
    nh   = (ctx.hr == 2'd2) ? {1'b0, ctx.h} - 13'd2 : {1'b0, ctx.h} + 13'd1;
    b4n  = h3[13:0] + {1'b0, nh};
    b4p  = h3[13:0] + {1'b0, ctx.p};
    vh   = vertex_count + {1'b0, eh.edge_id};
    vp   = vertex_count + {1'b0, ep.edge_id};
    e2h  = {edge_count, 1'b0} + {2'b00, ctx.h};
    edge0  = {1'b0, eh.edge_id, c0};
    edge2  = {1'b0, ep.edge_id, c2};
    face_h = {1'b0, ctx.h};
    face3  = halfedge_count + {2'b00, ctx.hq};

    case (slot)
      lhr_pkg::SLOT_CORNER0: begin
        child = '{idx: b, twin: t0, nxt: b + 14'd1, prv: b + 14'd2,
                  vertex: {1'b0, eh.vertex}, edge_id: edge0, face: face_h, last: 1'b0};
      end
      lhr_pkg::SLOT_CORNER1: begin
        child = '{idx: b + 14'd1, twin: tw1, nxt: b + 14'd2, prv: b,
                  vertex: vh, edge_id: e2h, face: face_h, last: 1'b0};
      end
      lhr_pkg::SLOT_CORNER2: begin
        child = '{idx: b + 14'd2, twin: tp3, nxt: b, prv: b + 14'd1,
                  vertex: vp, edge_id: edge2, face: face_h, last: 1'b0};
      end
      lhr_pkg::SLOT_INNER: begin
        child = '{idx: tw1[13:0], twin: {1'b0, b + 14'd1}, nxt: b4n, prv: b4p,
                  vertex: vp, edge_id: e2h, face: face3, last: 1'b1};
      end
      default: begin
        child = '0;
      end
    endcase
  end

endmodule

// File: rtl/core/loop_halfedge_refine.sv
// ----------------------------------------------------------------------------
// Loop subdivision halfedge refinement
// Halfedge table with per-halfedge refinement into four child halfedges.
// ----------------------------------------------------------------------------
// Input transactions carry a kind in s_tuser. A load writes one table entry
// (twin, vertex, edge) and produces no output. A refine names halfedge h and
// produces four output transactions: children 3h, 3h+1, 3h+2 and 3H+h, the
// last one marked with m_tlast. Counts are set on the cfg port while idle.
// A refine reads entries h and prev(h) from the table in its acceptance
// cycle; read data and context are registered, then the child stage loads
// the first child into the output register and the rest follow one per
// cycle while m_tready does not stall them. The single child stage holds one
// refine; the next is accepted as its fourth child enters the output register.
// Reset clears the pipeline and the count registers. The table is not
// cleared: an entry must be loaded before a refine reads it.
// When m_tready is low the output register holds its child, the child
// sequencer pauses and s_tready stays low until the last child can advance.
// ----------------------------------------------------------------------------
`include "loop_halfedge_refine_assert.svh"

module loop_halfedge_refine #(
  parameter int MAX_HALFEDGES = 4096
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [55:0]  s_tdata,   // index, twin_in, vertex_in, edge_in
  input  logic         s_tuser,   // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // child_index, child_twin, child_next, child_prev,
                                  // child_vertex, child_edge, child_face
  output logic         m_tlast,   // last
  input  logic         cfg_wr_en,
  input  logic [lhr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lhr_pkg::CFG_W-1:0]     cfg_data
);

  localparam int AW = $clog2(MAX_HALFEDGES);

  logic [12:0] halfedge_count;
  logic [12:0] vertex_count;
  logic [12:0] edge_count;

  logic                            accept;
  logic                            is_refine;
  logic [11:0]                     in_h;
  lhr_pkg::entry_t                 in_entry;
  logic [lhr_pkg::DIV3_PW-1:0]     hq_prod;
  lhr_pkg::ctx_t                   ctx_next;
  lhr_pkg::ctx_t                   ctx;
  logic                            s1_valid;
  logic [1:0]                      k;
  logic                            out_load;
  logic                            s1_release;
  lhr_pkg::entry_t                 ent_h;
  lhr_pkg::entry_t                 ent_p;
  lhr_pkg::child_t                 child;

  always_ff @(posedge clk) begin
    if (rst) begin
      halfedge_count <= '0;
      vertex_count   <= '0;
      edge_count     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lhr_pkg::REG_HALFEDGE_COUNT: halfedge_count <= cfg_data;
        lhr_pkg::REG_VERTEX_COUNT:   vertex_count   <= cfg_data;
        lhr_pkg::REG_EDGE_COUNT:     edge_count     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_h       = s_tdata[11:0];
  assign in_entry   = '{twin: s_tdata[24:12], vertex: s_tdata[36:25], edge_id: s_tdata[48:37]};
  assign accept     = s_tvalid && s_tready;
  assign is_refine  = (s_tuser == lhr_pkg::KIND_REFINE);
  assign out_load   = s1_valid && (!m_tvalid || m_tready);
  assign s1_release = out_load && (k == lhr_pkg::SLOT_INNER);
  assign s_tready   = !s1_valid || s1_release;

  always_comb begin
    hq_prod     = lhr_pkg::DIV3_PW'(in_h) * lhr_pkg::DIV3_PW'(lhr_pkg::DIV3_MUL);
    ctx_next.h  = in_h;
    ctx_next.hr = lhr_pkg::mod3_12(in_h);
    ctx_next.hq = 11'(hq_prod >> lhr_pkg::DIV3_SHIFT);
    ctx_next.p  = (ctx_next.hr == 2'd0) ? {1'b0, in_h} + 13'd2 : {1'b0, in_h} - 13'd1;
    ctx_next.h_ok = (32'(in_h) < MAX_HALFEDGES);
    ctx_next.p_ok = (32'(ctx_next.p) < MAX_HALFEDGES);
  end

  lhr_table #(
    .DEPTH (MAX_HALFEDGES)
  ) u_table (
    .clk     (clk),
    .we      (accept && !is_refine && ctx_next.h_ok),
    .waddr   (AW'(in_h)),
    .wdata   (in_entry),
    .re      (accept && is_refine),
    .raddr_a (AW'(in_h)),
    .raddr_b (AW'(ctx_next.p)),
    .rdata_a (ent_h),
    .rdata_b (ent_p)
  );

  lhr_child u_child (
    .ctx            (ctx),
    .ent_h          (ent_h),
    .ent_p          (ent_p),
    .halfedge_count (halfedge_count),
    .vertex_count   (vertex_count),
    .edge_count     (edge_count),
    .slot           (k),
    .child          (child)
  );

  always_ff @(posedge clk) begin
    if (accept && is_refine) begin
      ctx <= ctx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      k        <= lhr_pkg::SLOT_CORNER0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept && is_refine) begin
        s1_valid <= 1'b1;
      end else if (s1_release) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        k <= k + 2'd1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'b0000000, child.face, child.edge_id, child.vertex, child.prv,
                  child.nxt, child.twin, child.idx};
      m_tlast <= child.last;
    end
  end

  `LHR_ASSERT_NXT(a_refine_enters_stage, clk, rst, accept && is_refine,
                  s1_valid && (k == lhr_pkg::SLOT_CORNER0),
                  "refine transaction did not start at the first child")
  `LHR_ASSERT_IMP(a_slot_needs_stage, clk, rst, k != lhr_pkg::SLOT_CORNER0, s1_valid,
                  "child slot advanced without a refine in progress")
  `LHR_ASSERT_NXT(a_ctx_held, clk, rst, s1_valid && !s1_release,
                  s1_valid && $stable(ctx), "refine context changed before its last child")
  `LHR_ASSERT_NXT(a_last_single, clk, rst, m_tvalid && m_tready && m_tlast,
                  !(m_tvalid && m_tlast), "two last children in a row")

endmodule
